// File: rtl/core/qenc_pkg.sv
`timescale 1ns / 1ps

package qenc_pkg;

	// event source codes
	localparam logic [1:0] MODE_LINE_A = 2'd0;
	localparam logic [1:0] MODE_LINE_B = 2'd1;
	localparam logic [1:0] MODE_SWITCH = 2'd2;

	// encoder line levels as {line_b, line_a}
	localparam logic [1:0] LEVELS_CW_ARM   = 2'b10;
	localparam logic [1:0] LEVELS_CCW_ARM  = 2'b01;
	localparam logic [1:0] LEVELS_BOTH_LOW = 2'b00;

	// debounce window length after reset, in ms
	localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

	// step report codes
	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_UP   = 2'd1,
		STEP_DOWN = 2'd2
	} step_t;

	// one pin event
	typedef struct packed {
		logic [1:0]  mode;
		logic        line_a;
		logic        line_b;
		logic        switch_level;
		logic [31:0] time_ms;
	} qenc_in_t;

	// one result
	typedef struct packed {
		logic signed [15:0] position_count;
		logic [1:0]         step_code;
		logic               press_seen;
		logic [15:0]        press_total;
	} qenc_out_t;

endpackage

// File: rtl/core/qenc_if.sv
`timescale 1ns / 1ps

// pin event channel
interface qenc_in_if import qenc_pkg::*; ();
	logic     valid;
	logic     ready;
	qenc_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// result channel
interface qenc_out_if import qenc_pkg::*; ();
	logic      valid;
	logic      ready;
	qenc_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/quadrature_encoder_with_key_debounce_top.sv
// path: an accepted event beat is held in the input register, and its result then in the result register
// throughput: one event per cycle unless the result stalls; a stalled result
// holds one event in the result register and up to one in the input register
// reset: arst_n clears both valid flags, the arm flags, the step and press
// counts and the debounce window, and loads debounce_ms with 20
`timescale 1ns / 1ps

module quadrature_encoder_with_key_debounce_top import qenc_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	qenc_in_if.sink     in_ch,
	qenc_out_if.source  out_ch
);

	localparam int PosW = (COUNT_BITS < 16) ? COUNT_BITS : 16;

	logic                  valid_s1;
	qenc_in_t              data_s1;
	logic                  out_valid_q;
	qenc_out_t             out_data_q;
	logic [15:0]           debounce_ms_q;
	logic                  cw_armed_q;
	logic                  ccw_armed_q;
	logic [COUNT_BITS-1:0] step_count_q;
	logic                  debounce_active_q;
	logic [31:0]           debounce_start_q;
	logic [15:0]           press_count_q;

	logic                  adv;
	logic                  load;
	logic [1:0]            levels;
	logic [31:0]           elapsed;
	logic                  cw_armed_d;
	logic                  ccw_armed_d;
	logic [COUNT_BITS-1:0] step_count_d;
	logic                  debounce_active_d;
	logic [31:0]           debounce_start_d;
	logic [15:0]           press_count_d;
	step_t                 step_d;
	logic                  press_d;

	// handshake
	assign adv         = !out_valid_q || out_ch.ready;
	assign load        = valid_s1 && adv;
	assign in_ch.ready = !valid_s1 || adv;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			debounce_ms_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			data_s1 <= in_ch.data;
		end
	end

	// event decode and next state
	assign levels  = {data_s1.line_b, data_s1.line_a};
	assign elapsed = data_s1.time_ms - debounce_start_q;

	always_comb begin
		cw_armed_d        = cw_armed_q;
		ccw_armed_d       = ccw_armed_q;
		step_count_d      = step_count_q;
		debounce_active_d = debounce_active_q;
		debounce_start_d  = debounce_start_q;
		press_count_d     = press_count_q;
		step_d            = STEP_NONE;
		press_d           = 1'b0;
		unique case (data_s1.mode)
			MODE_LINE_A: begin
				if (!cw_armed_q && levels == LEVELS_CW_ARM) begin
					cw_armed_d = 1'b1;
				end
				if (ccw_armed_q && levels == LEVELS_BOTH_LOW) begin
					cw_armed_d   = 1'b0;
					ccw_armed_d  = 1'b0;
					step_count_d = step_count_q + 1'b1;
					step_d       = STEP_UP;
				end
			end
			MODE_LINE_B: begin
				if (!ccw_armed_q && levels == LEVELS_CCW_ARM) begin
					ccw_armed_d = 1'b1;
				end
				if (cw_armed_q && levels == LEVELS_BOTH_LOW) begin
					cw_armed_d   = 1'b0;
					ccw_armed_d  = 1'b0;
					step_count_d = step_count_q - 1'b1;
					step_d       = STEP_DOWN;
				end
			end
			MODE_SWITCH: begin
				if (!data_s1.switch_level && !debounce_active_q) begin
					debounce_active_d = 1'b1;
					debounce_start_d  = data_s1.time_ms;
				end else if (debounce_active_q && elapsed >= 32'(debounce_ms_q)) begin
					// window expired: close it, count only if still low
					if (!data_s1.switch_level) begin
						press_count_d = press_count_q + 1'b1;
						press_d       = 1'b1;
					end
					debounce_active_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_armed_q        <= 1'b0;
			ccw_armed_q       <= 1'b0;
			step_count_q      <= '0;
			debounce_active_q <= 1'b0;
			debounce_start_q  <= '0;
			press_count_q     <= '0;
		end else if (load) begin
			cw_armed_q        <= cw_armed_d;
			ccw_armed_q       <= ccw_armed_d;
			step_count_q      <= step_count_d;
			debounce_active_q <= debounce_active_d;
			debounce_start_q  <= debounce_start_d;
			press_count_q     <= press_count_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q.position_count <= signed'(16'(step_count_d[PosW-1:0]));
			out_data_q.step_code      <= step_d;
			out_data_q.press_seen     <= press_d;
			out_data_q.press_total    <= press_count_d;
		end
	end

`ifndef SYNTHESIS
	// an up step advances the count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		load && step_d == STEP_UP |=>
		step_count_q == COUNT_BITS'($past(step_count_q) + 1'b1))
		else $error("up step did not increment the count");

	// a down step lowers the count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		load && step_d == STEP_DOWN |=>
		step_count_q == COUNT_BITS'($past(step_count_q) - 1'b1))
		else $error("down step did not decrement the count");

	// any step disarms both directions
	assert property (@(posedge clk) disable iff (!arst_n)
		load && step_d != STEP_NONE |=> !cw_armed_q && !ccw_armed_q)
		else $error("arm flags survive a step");

	// a counted press closes the window and bumps the press count
	assert property (@(posedge clk) disable iff (!arst_n)
		load && press_d |=>
		!debounce_active_q && press_count_q == 16'($past(press_count_q) + 1'b1))
		else $error("press bookkeeping wrong");

	// a result that reports a step never reports a press
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q.press_seen && out_data_q.step_code != STEP_NONE))
		else $error("step and press in one beat");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import qenc_pkg::*;

	// event source that the block ignores
	localparam logic [1:0] MODE_IGNORED = 2'd3;

	localparam int PHASE_EVENTS = 120;

	typedef struct {
		qenc_in_t  ev;
		bit        typed;
		qenc_out_t answer;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	qenc_in_if in_ch ();
	qenc_out_if out_ch ();

	quadrature_encoder_with_key_debounce_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// decoder state as the block should hold it
	logic        cw_arm;
	logic        ccw_arm;
	logic [15:0] position;
	logic        window_open;
	logic [31:0] window_start;
	logic [15:0] presses;
	logic [15:0] hold_ms;

	qenc_out_t   expected_results[$];
	table_row_t  directed_rows[$];
	int unsigned mismatches = 0;
	bit          idle_on = 1'b1;

	// side band that travels with each event beat
	bit          typed_valid;
	qenc_out_t   typed_answer;

	// random stimulus state
	logic [1:0]  enc_idx = 2'd0;
	bit          spin_up = 1'b1;
	logic [31:0] now_ms = 32'hFFFF_F000;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// next state and result for one pin event
	function automatic qenc_out_t decode_event(input qenc_in_t ev);
		qenc_out_t   res;
		logic [1:0]  levels;
		logic [31:0] age;
		levels = {ev.line_b, ev.line_a};
		age = ev.time_ms - window_start;
		res.step_code = STEP_NONE;
		res.press_seen = 1'b0;
		case (ev.mode)
			MODE_LINE_A: begin
				if (!cw_arm && levels == LEVELS_CW_ARM)
					cw_arm = 1'b1;
				if (ccw_arm && levels == LEVELS_BOTH_LOW) begin
					cw_arm = 1'b0;
					ccw_arm = 1'b0;
					position = position + 16'd1;
					res.step_code = STEP_UP;
				end
			end
			MODE_LINE_B: begin
				if (!ccw_arm && levels == LEVELS_CCW_ARM)
					ccw_arm = 1'b1;
				if (cw_arm && levels == LEVELS_BOTH_LOW) begin
					cw_arm = 1'b0;
					ccw_arm = 1'b0;
					position = position - 16'd1;
					res.step_code = STEP_DOWN;
				end
			end
			MODE_SWITCH: begin
				if (!ev.switch_level && !window_open) begin
					window_open = 1'b1;
					window_start = ev.time_ms;
				end else if (window_open && age >= {16'd0, hold_ms}) begin
					if (!ev.switch_level) begin
						presses = presses + 16'd1;
						res.press_seen = 1'b1;
					end
					window_open = 1'b0;
				end
			end
			default: ;
		endcase
		res.position_count = position;
		res.press_total = presses;
		return res;
	endfunction

	function automatic void check_field(input string field, input int want, input int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s: expected %0d, got %0d", field, want, got);
		end
	endfunction

	function automatic void check_result(input qenc_out_t got);
		qenc_out_t want;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result beat with none expected: position %0d step %0d press %0b total %0d",
					got.position_count, got.step_code, got.press_seen, got.press_total);
			return;
		end
		want = expected_results.pop_front();
		check_field("position_count", want.position_count, got.position_count);
		check_field("step_code", want.step_code, got.step_code);
		check_field("press_seen", want.press_seen, got.press_seen);
		check_field("press_total", want.press_total, got.press_total);
	endfunction

	function automatic qenc_out_t result_of(input logic signed [15:0] pos, input logic [1:0] code,
			input logic seen, input logic [15:0] total);
		qenc_out_t res;
		res.position_count = pos;
		res.step_code = code;
		res.press_seen = seen;
		res.press_total = total;
		return res;
	endfunction

	function automatic void add_row(input logic [1:0] md, input logic la, input logic lb,
			input logic sw, input logic [31:0] t, input bit typed = 1'b0,
			input qenc_out_t answer = '0);
		table_row_t row;
		row.ev.mode = md;
		row.ev.line_a = la;
		row.ev.line_b = lb;
		row.ev.switch_level = sw;
		row.ev.time_ms = t;
		row.typed = typed;
		row.answer = answer;
		directed_rows.push_back(row);
	endfunction

	// gray code position to {line_b, line_a}
	function automatic logic [1:0] levels_at(input logic [1:0] idx);
		return {idx[1], idx[1] ^ idx[0]};
	endfunction

	// mostly clean rotation and press sequences, some noise
	function automatic qenc_in_t random_event();
		qenc_in_t    ev;
		logic [1:0]  prev;
		logic [1:0]  lv;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		ev.switch_level = $urandom_range(0, 1);
		if (pick < 45) begin
			prev = levels_at(enc_idx);
			enc_idx = spin_up ? enc_idx + 2'd1 : enc_idx - 2'd1;
			if ($urandom_range(0, 15) == 0)
				spin_up = !spin_up;
			lv = levels_at(enc_idx);
			ev.mode = (prev[0] != lv[0]) ? MODE_LINE_A : MODE_LINE_B;
			{ev.line_b, ev.line_a} = lv;
			now_ms = now_ms + $urandom_range(0, 3);
			ev.time_ms = now_ms;
		end else if (pick < 75) begin
			ev.mode = MODE_SWITCH;
			ev.switch_level = ($urandom_range(0, 9) < 7) ? 1'b0 : 1'b1;
			{ev.line_b, ev.line_a} = levels_at(enc_idx);
			// steps short of, around and past the debounce time
			case ($urandom_range(0, 3))
				0: now_ms = now_ms + $urandom_range(0, hold_ms / 2);
				1: now_ms = now_ms + {16'd0, hold_ms} + $urandom_range(0, 2) - 32'd1;
				2: now_ms = now_ms + $urandom_range(0, 2 * hold_ms + 2);
				default: now_ms = now_ms + $urandom_range(0, 5);
			endcase
			ev.time_ms = now_ms;
		end else if (pick < 90) begin
			ev.mode = $urandom_range(0, 3);
			ev.line_a = $urandom_range(0, 1);
			ev.line_b = $urandom_range(0, 1);
			ev.time_ms = $urandom();
		end else begin
			// contact bounce on an encoder line
			enc_idx = $urandom_range(0, 3);
			ev.mode = $urandom_range(0, 1) ? MODE_LINE_B : MODE_LINE_A;
			{ev.line_b, ev.line_a} = levels_at(enc_idx);
			ev.time_ms = now_ms;
		end
		return ev;
	endfunction

	task automatic send_event(input qenc_in_t ev, input bit typed = 1'b0,
			input qenc_out_t answer = '0);
		int unsigned gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 19);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= ev;
		typed_valid <= typed;
		typed_answer <= answer;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// let the block drain before touching the register
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_debounce(input logic [15:0] ms);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= ms;
		@(posedge clk);
		cfg_we <= 1'b0;
		hold_ms = ms;
	endtask

	// result sink with bursts of back pressure
	initial begin
		int unsigned stall;
		stall = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall != 0)
				stall--;
			else if (idle_on && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 19);
			out_ch.ready <= (stall == 0);
		end
	end

	// predict on every event beat, check every result beat
	initial begin
		qenc_out_t want;
		forever begin
			@(posedge clk);
			if (arst_n && in_ch.valid && in_ch.ready) begin
				want = decode_event(in_ch.data);
				if (typed_valid)
					want = typed_answer;
				expected_results.push_back(want);
			end
			if (arst_n && out_ch.valid && out_ch.ready)
				check_result(out_ch.data);
		end
	end

	initial begin
		logic [15:0] phase_ms [5];
		qenc_in_t    ev;
		int          counted;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		typed_valid <= 1'b0;
		typed_answer <= '0;

		cw_arm = 1'b0;
		ccw_arm = 1'b0;
		position = '0;
		window_open = 1'b0;
		window_start = '0;
		presses = '0;
		hold_ms = DEBOUNCE_RESET;

		// ignored event right after reset
		add_row(MODE_IGNORED, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1,
			result_of(16'sd0, STEP_NONE, 1'b0, 16'd0));
		// arm on A, step down on B, count wraps below zero
		add_row(MODE_LINE_A, 1'b0, 1'b1, 1'b1, 32'd0);
		add_row(MODE_LINE_B, 1'b0, 1'b0, 1'b1, 32'd0, 1'b1,
			result_of(-16'sd1, STEP_DOWN, 1'b0, 16'd0));
		// arm on B, step up on A, count wraps back to zero
		add_row(MODE_LINE_B, 1'b1, 1'b0, 1'b0, 32'd1);
		add_row(MODE_LINE_A, 1'b0, 1'b0, 1'b0, 32'd1, 1'b1,
			result_of(16'sd0, STEP_UP, 1'b0, 16'd0));
		// both lines high, and both low with nothing armed
		add_row(MODE_LINE_A, 1'b1, 1'b1, 1'b1, 32'd2);
		add_row(MODE_LINE_B, 1'b1, 1'b1, 1'b1, 32'd2);
		add_row(MODE_LINE_A, 1'b0, 1'b0, 1'b1, 32'd3);
		// both directions armed at once
		add_row(MODE_LINE_B, 1'b1, 1'b0, 1'b1, 32'd4);
		add_row(MODE_LINE_A, 1'b0, 1'b1, 1'b1, 32'd4);
		add_row(MODE_LINE_B, 1'b0, 1'b0, 1'b1, 32'd5);
		// press one ms short of the window, then exactly at it
		add_row(MODE_SWITCH, 1'b0, 1'b0, 1'b0, 32'd100);
		add_row(MODE_SWITCH, 1'b0, 1'b0, 1'b0, 32'd119);
		add_row(MODE_SWITCH, 1'b0, 1'b0, 1'b0, 32'd120, 1'b1,
			result_of(-16'sd1, STEP_NONE, 1'b1, 16'd1));
		// switch high with no window open
		add_row(MODE_SWITCH, 1'b1, 1'b1, 1'b1, 32'd200);
		// window expires across the time wrap with the switch released
		add_row(MODE_SWITCH, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0);
		add_row(MODE_SWITCH, 1'b0, 1'b0, 1'b1, 32'd4);
		// press across the time wrap
		add_row(MODE_SWITCH, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF);
		add_row(MODE_SWITCH, 1'b1, 1'b1, 1'b0, 32'd19, 1'b1,
			result_of(-16'sd1, STEP_NONE, 1'b1, 16'd2));
		// ignored event with a low switch leaves the window closed
		add_row(MODE_IGNORED, 1'b0, 1'b0, 1'b0, 32'd0);
		add_row(MODE_SWITCH, 1'b0, 1'b0, 1'b1, 32'd0);

		phase_ms[0] = 16'd0;
		phase_ms[1] = 16'hFFFF;
		phase_ms[2] = 16'd1;
		phase_ms[3] = $urandom_range(2, 5000);
		phase_ms[4] = DEBOUNCE_RESET;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].answer);

		// random phases, one debounce setting each, last one without idling
		foreach (phase_ms[p]) begin
			set_debounce(phase_ms[p]);
			idle_on = (p != 4);
			counted = 0;
			while (counted < PHASE_EVENTS) begin
				ev = random_event();
				send_event(ev);
				if (ev.mode != MODE_IGNORED)
					counted++;
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
